### sv/tlp_pkg.sv
package tlp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_AMBIG    = 3'd1,
    ST_HELD     = 3'd2,
    ST_NOTAP    = 3'd3,
    ST_TAP      = 3'd4,
    ST_RELEASED = 3'd5
  } gesture_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_READ,
    C_MUL1,
    C_MUL2,
    C_COMMIT
  } ctrl_state_t;

  localparam logic [1:0] CFG_MAX_MOVE   = 2'd0;
  localparam logic [1:0] CFG_MAX_SPEED  = 2'd1;
  localparam logic [1:0] CFG_LONG_PRESS = 2'd2;

  localparam logic [15:0] MAX_MOVE_RST   = 16'd60;
  localparam logic [15:0] MAX_SPEED_RST  = 16'd1024;
  localparam logic [15:0] LONG_PRESS_RST = 16'd500;

  typedef struct packed {
    gesture_t    st;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage

### sv/tlp_ctrl.sv
module tlp_ctrl import tlp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE:   if (in_valid) state_nxt = C_READ;
      C_READ:   state_nxt = C_MUL1;
      C_MUL1:   state_nxt = C_MUL2;
      C_MUL2:   state_nxt = C_COMMIT;
      C_COMMIT: if (!status.out_blocked) state_nxt = C_IDLE;
      default:  state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.mul1    = 1'b0;
    cmd.mul2    = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      C_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      C_MUL1:   cmd.mul1 = 1'b1;
      C_MUL2:   cmd.mul2 = 1'b1;
      C_COMMIT: cmd.commit = !status.out_blocked;
      default: ;
    endcase
  end

endmodule

### sv/tlp_dp.sv
module tlp_dp import tlp_pkg::*; #(
  parameter int MAX_POINTERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic [3:0]  in_pointer_id,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [16:0] in_move_dx,
  input  logic [16:0] in_move_dy,
  input  logic [15:0] in_elapsed_ms,
  input  logic [31:0] in_stamp_ms,
  input  logic        in_touch_down,
  input  logic        in_touch_up,
  input  logic        in_cancel_flag,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_tap_status,
  output logic        out_status_changed,
  output logic [3:0]  out_result_pointer
);

  localparam int IW = (MAX_POINTERS > 1) ? $clog2(MAX_POINTERS) : 1;

  // configuration
  logic [15:0] move_lim_r, speed_lim_r, hold_lim_r;

  // captured transaction
  logic [3:0]  ptr_r;
  logic [15:0] x_r, y_r, dt_r;
  logic [16:0] dx_r, dy_r;
  logic [31:0] stamp_r;
  logic        down_r, up_r, cancel_r;

  // pointer table
  entry_t                  mem [MAX_POINTERS];
  entry_t                  rd_r;
  logic                    rd_valid_r;
  logic [MAX_POINTERS-1:0] valid_r;
  logic [7:0]              ptr_ext;
  logic [IW-1:0]           idx;
  logic                    in_range;

  // stage 1
  entry_t             ent;
  logic [15:0]        base_x, base_y;
  logic [31:0]        base_stamp, hold_diff;
  logic signed [16:0] ex, ey, mdx, mdy;
  logic signed [33:0] ex_sq, ey_sq, mx_sq, my_sq;
  logic [32:0]        ex2_r, ey2_r, mx2_r, my2_r;
  logic [31:0]        lim2_r, rhs_r;
  logic               long_r;
  gesture_t           old_st_r;
  logic [15:0]        bx_r, by_r;
  logic [31:0]        bstamp_r;

  // stage 2
  logic [33:0] d2_r, m2_r;
  logic [63:0] rhs2_r;

  // decision
  logic     moved, terminal;
  gesture_t st_c, st_nxt;

  logic     out_valid_r, out_valid_nxt;
  gesture_t out_status_r;
  logic     out_changed_r;
  logic [3:0] out_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_lim_r  <= MAX_MOVE_RST;
      speed_lim_r <= MAX_SPEED_RST;
      hold_lim_r  <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_MOVE:   move_lim_r  <= cfg_wdata;
        CFG_MAX_SPEED:  speed_lim_r <= cfg_wdata;
        CFG_LONG_PRESS: hold_lim_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ptr_r    <= in_pointer_id;
      x_r      <= in_pos_x;
      y_r      <= in_pos_y;
      dx_r     <= in_move_dx;
      dy_r     <= in_move_dy;
      dt_r     <= in_elapsed_ms;
      stamp_r  <= in_stamp_ms;
      down_r   <= in_touch_down;
      up_r     <= in_touch_up;
      cancel_r <= in_cancel_flag;
    end
  end

  assign ptr_ext  = {4'b0, ptr_r};
  assign idx      = ptr_ext[IW-1:0];
  assign in_range = int'(ptr_r) < MAX_POINTERS;

  always_ff @(posedge clk) begin
    rd_r <= mem[idx];
    if (cmd.commit && in_range && !terminal) begin
      mem[idx] <= '{st: st_nxt, x: bx_r, y: by_r, stamp: bstamp_r};
    end
  end

  // an entry without its valid bit reads as idle with zero down data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[idx];
      if (cmd.commit && in_range) begin
        valid_r[idx] <= !terminal;
      end
    end
  end

  always_comb begin
    ent        = rd_valid_r ? rd_r : '0;
    base_x     = down_r ? x_r : ent.x;
    base_y     = down_r ? y_r : ent.y;
    base_stamp = down_r ? stamp_r : ent.stamp;
    ex         = $signed({x_r[15], x_r}) - $signed({base_x[15], base_x});
    ey         = $signed({y_r[15], y_r}) - $signed({base_y[15], base_y});
    mdx        = $signed(dx_r);
    mdy        = $signed(dy_r);
    ex_sq      = ex * ex;
    ey_sq      = ey * ey;
    mx_sq      = mdx * mdx;
    my_sq      = mdy * mdy;
    hold_diff  = stamp_r - base_stamp;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      ex2_r    <= ex_sq[32:0];
      ey2_r    <= ey_sq[32:0];
      mx2_r    <= mx_sq[32:0];
      my2_r    <= my_sq[32:0];
      lim2_r   <= 32'(move_lim_r) * 32'(move_lim_r);
      rhs_r    <= 32'(speed_lim_r) * 32'(dt_r);
      long_r   <= hold_diff > 32'(hold_lim_r);
      old_st_r <= ent.st;
      bx_r     <= base_x;
      by_r     <= base_y;
      bstamp_r <= base_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      d2_r   <= 34'(ex2_r) + 34'(ey2_r);
      m2_r   <= 34'(mx2_r) + 34'(my2_r);
      rhs2_r <= 64'(rhs_r) * 64'(rhs_r);
    end
  end

  always_comb begin
    moved = (d2_r > 34'(lim2_r)) ||
            ((dt_r != '0) && (64'({m2_r, 16'b0}) > rhs2_r));
    st_c = cancel_r ? ST_NOTAP : old_st_r;
    st_nxt = st_c;
    case (st_c)
      ST_IDLE: begin
        if (down_r) st_nxt = ST_AMBIG;
      end
      ST_AMBIG: begin
        if (moved)       st_nxt = ST_NOTAP;
        else if (up_r)   st_nxt = ST_TAP;
        else if (long_r) st_nxt = ST_HELD;
      end
      ST_HELD: begin
        if (moved)     st_nxt = ST_NOTAP;
        else if (up_r) st_nxt = ST_RELEASED;
      end
      default: ;
    endcase
    terminal = st_nxt inside {ST_NOTAP, ST_TAP, ST_RELEASED};
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r  <= in_range ? st_nxt : ST_IDLE;
      out_changed_r <= in_range && (st_nxt != old_st_r);
      out_ptr_r     <= ptr_r;
    end
  end

  assign status.out_blocked = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_tap_status     = out_status_r;
  assign out_status_changed = out_changed_r;
  assign out_result_pointer = out_ptr_r;

endmodule

### sv/tap_long_press_recognizer_top.sv
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall   | pointer_id, pos, move delta, elapsed, stamp, flags
// out_    | output    | out_valid / out_stall | tap_status, status_changed, result_pointer
// cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// One transaction at a time, through accept, table read, squares, speed square
// and sums, decide and write back; no new input is taken until write-back.
// The registered table read port and the two multiply stages give these steps.
// Synchronous active-low reset: all pointers idle, thresholds 60 / 1024 / 500.
// A held result sits in the output register while the next transaction is taken;
// only the decide step waits on out_stall.
module tap_long_press_recognizer_top import tlp_pkg::*; #(
  parameter int MAX_POINTERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_pointer_id,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [16:0] in_move_dx,
  input  logic signed [16:0] in_move_dy,
  input  logic [15:0] in_elapsed_ms,
  input  logic [31:0] in_stamp_ms,
  input  logic        in_touch_down,
  input  logic        in_touch_up,
  input  logic        in_cancel_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_tap_status,
  output logic        out_status_changed,
  output logic [3:0]  out_result_pointer
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tlp_dp #(
    .MAX_POINTERS (MAX_POINTERS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_pointer_id      (in_pointer_id),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_move_dx         (in_move_dx),
    .in_move_dy         (in_move_dy),
    .in_elapsed_ms      (in_elapsed_ms),
    .in_stamp_ms        (in_stamp_ms),
    .in_touch_down      (in_touch_down),
    .in_touch_up        (in_touch_up),
    .in_cancel_flag     (in_cancel_flag),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tap_status     (out_tap_status),
    .out_status_changed (out_status_changed),
    .out_result_pointer (out_result_pointer)
  );

  // an accepted transaction keeps the input side busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous transaction in flight");

  // an idle result never reports a change
  a_idle_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_tap_status == ST_IDLE)) |-> !out_status_changed)
    else $error("idle result flagged as changed");

  // terminal results are never stored, so they always differ from the old state
  a_terminal_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_tap_status == ST_NOTAP || out_tap_status == ST_TAP ||
                   out_tap_status == ST_RELEASED)) |-> out_status_changed)
    else $error("terminal result without change flag");

  // commit only happens when the output register can take it
  a_commit_space: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

endmodule

### dv/testbench.sv
module testbench;
  import tlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]         ptr;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [15:0]        dt;
    logic [31:0]        stamp;
    logic               down;
    logic               up;
    logic               cancel;
  } touch_t;

  typedef struct {
    touch_t   ev;
    bit       known;
    gesture_t st;
    logic     chg;
  } touch_row_t;

  typedef struct {
    gesture_t   st;
    logic       chg;
    logic [3:0] ptr;
  } gesture_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MAX_MOVE;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_pointer_id = '0;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic signed [16:0] in_move_dx = '0;
  logic signed [16:0] in_move_dy = '0;
  logic [15:0] in_elapsed_ms = '0;
  logic [31:0] in_stamp_ms = '0;
  logic        in_touch_down = 1'b0;
  logic        in_touch_up = 1'b0;
  logic        in_cancel_flag = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_tap_status;
  logic        out_status_changed;
  logic [3:0]  out_result_pointer;

  // expectation typed into the stimulus table, travels alongside the payload
  bit       row_known = 1'b0;
  gesture_t row_st = ST_IDLE;
  logic     row_chg = 1'b0;

  bit no_idle = 1'b0;
  int fail_count = 0;

  gesture_result_t status_due_q[$];

  tap_long_press_recognizer_top u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  logic [15:0]        m_move, m_speed, m_lpt;
  gesture_t           m_state [16];
  logic signed [15:0] m_x [16];
  logic signed [15:0] m_y [16];
  logic [31:0]        m_stamp [16];

  function automatic void predict_gesture(input touch_t ev, output gesture_t st,
                                          output logic chg);
    gesture_t prev;
    longint ex, ey, mx, my;
    longint unsigned d2, lim, m2, rhs;
    logic [31:0] held_ms;
    logic moved, long_hold;
    int p;
    p = ev.ptr;
    prev = m_state[p];
    st = prev;
    // a down stores its data first, so it sees zero distance
    if (ev.down) begin
      m_x[p] = ev.x;
      m_y[p] = ev.y;
      m_stamp[p] = ev.stamp;
    end
    if (ev.cancel) st = ST_NOTAP;
    ex = longint'(ev.x) - longint'(m_x[p]);
    ey = longint'(ev.y) - longint'(m_y[p]);
    d2 = ex * ex + ey * ey;
    lim = m_move;
    moved = d2 > lim * lim;
    if (ev.dt != 0) begin
      mx = ev.dx;
      my = ev.dy;
      m2 = mx * mx + my * my;
      rhs = longint'(m_speed) * longint'(ev.dt);
      if ((m2 << 16) > rhs * rhs) moved = 1'b1;
    end
    held_ms = ev.stamp - m_stamp[p];
    long_hold = held_ms > {16'd0, m_lpt};
    case (st)
      ST_IDLE: begin
        if (ev.down) st = ST_AMBIG;
      end
      ST_AMBIG: begin
        if (moved) st = ST_NOTAP;
        else if (ev.up) st = ST_TAP;
        else if (long_hold) st = ST_HELD;
      end
      ST_HELD: begin
        if (moved) st = ST_NOTAP;
        else if (ev.up) st = ST_RELEASED;
      end
      default: ;
    endcase
    chg = (st != prev);
    if (st == ST_NOTAP || st == ST_TAP || st == ST_RELEASED) begin
      m_state[p] = ST_IDLE;
      m_x[p] = '0;
      m_y[p] = '0;
      m_stamp[p] = '0;
    end else begin
      m_state[p] = st;
    end
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    touch_t ev;
    gesture_t st;
    logic chg;
    gesture_result_t want;
    if (!rst_n) begin
      m_move = MAX_MOVE_RST;
      m_speed = MAX_SPEED_RST;
      m_lpt = LONG_PRESS_RST;
      for (int i = 0; i < 16; i++) begin
        m_state[i] = ST_IDLE;
        m_x[i] = '0;
        m_y[i] = '0;
        m_stamp[i] = '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_MOVE:   m_move = cfg_wdata;
          CFG_MAX_SPEED:  m_speed = cfg_wdata;
          CFG_LONG_PRESS: m_lpt = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        ev.ptr = in_pointer_id;
        ev.x = in_pos_x;
        ev.y = in_pos_y;
        ev.dx = in_move_dx;
        ev.dy = in_move_dy;
        ev.dt = in_elapsed_ms;
        ev.stamp = in_stamp_ms;
        ev.down = in_touch_down;
        ev.up = in_touch_up;
        ev.cancel = in_cancel_flag;
        predict_gesture(ev, st, chg);
        if (row_known) begin
          st = row_st;
          chg = row_chg;
        end
        status_due_q.push_back('{st: st, chg: chg, ptr: ev.ptr});
      end
      if (out_valid && !out_stall) begin
        if (status_due_q.size() == 0) begin
          flag_error($sformatf("unexpected result: status %0d changed %0b pointer %0d",
                               out_tap_status, out_status_changed, out_result_pointer));
        end else begin
          want = status_due_q.pop_front();
          if (out_tap_status !== want.st || out_status_changed !== want.chg ||
              out_result_pointer !== want.ptr)
            flag_error($sformatf({"mismatch: status %0d/%0d changed %0b/%0b ",
                                  "pointer %0d/%0d (expected/actual)"},
                                 want.st, out_tap_status, want.chg, out_status_changed,
                                 want.ptr, out_result_pointer));
        end
      end
    end
  end

  // ------------------------------------------------------- result back-pressure
  int stall_left = 0;
  bit stall_hi = 1'b0;

  always @(posedge clk) begin
    int r;
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (no_idle || r < 45) begin
        stall_hi = 1'b0;
        stall_left = $urandom_range(0, 12);
      end else if (r < 90) begin
        stall_hi = 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        stall_hi = 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
    out_stall <= stall_hi;
  end

  // ----------------------------------------------------------------- stimulus
  logic [15:0] gen_move = MAX_MOVE_RST;
  logic [15:0] gen_speed = MAX_SPEED_RST;
  logic [15:0] gen_lpt = LONG_PRESS_RST;
  bit          gen_live [16];
  logic [15:0] gen_x [16];
  logic [15:0] gen_y [16];
  logic [31:0] gen_stamp [16];
  logic [31:0] gen_down_stamp [16];

  function automatic touch_row_t mk(input int ptr, input int x, input int y, input int dx,
                                    input int dy, input int dt, input logic [31:0] stamp,
                                    input bit dn, input bit up, input bit cn,
                                    input bit known, input gesture_t st, input bit chg);
    touch_row_t r;
    r.ev = '{ptr: ptr, x: x, y: y, dx: dx, dy: dy, dt: dt, stamp: stamp,
             down: dn, up: up, cancel: cn};
    r.known = known;
    r.st = st;
    r.chg = chg;
    return r;
  endfunction

  function automatic int spread(input int a);
    return $urandom_range(0, 2 * a) - a;
  endfunction

  function automatic touch_t next_touch();
    touch_t ev;
    int p, off, lim, step;
    if ($urandom_range(0, 99) < 18) begin
      ev.ptr = $urandom;
      ev.x = $urandom;
      ev.y = $urandom;
      ev.dx = spread(65535);
      ev.dy = spread(65535);
      ev.dt = $urandom;
      ev.stamp = $urandom;
      ev.down = $urandom;
      ev.up = $urandom;
      ev.cancel = $urandom_range(0, 3) == 0;
      return ev;
    end
    p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    ev.ptr = p;
    ev.up = 1'b0;
    ev.cancel = $urandom_range(0, 99) < 4;
    ev.down = !gen_live[p] || $urandom_range(0, 99) < 4;
    ev.dt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
    lim = ((int'(gen_speed) * int'(ev.dt)) >> 8) + 1;
    if (lim > 65535) lim = 65535;
    ev.dx = spread(lim);
    ev.dy = spread(lim);
    if (ev.down) begin
      step = $urandom_range(0, 200);
      gen_stamp[p] += step;
      ev.x = $urandom;
      ev.y = $urandom;
      gen_x[p] = ev.x;
      gen_y[p] = ev.y;
      gen_down_stamp[p] = gen_stamp[p];
    end else begin
      // hold times land on either side of the long-press threshold
      if ($urandom_range(0, 5) == 0)
        gen_stamp[p] = gen_down_stamp[p] + gen_lpt + $urandom_range(0, 1);
      else
        gen_stamp[p] += ev.dt;
      off = ($urandom_range(0, 99) < 15) ? (int'(gen_move) * 5) / 4 + 2
                                          : (int'(gen_move) * 3) / 4;
      ev.x = gen_x[p] + spread(off);
      ev.y = gen_y[p] + spread(off);
      ev.up = $urandom_range(0, 99) < 20;
    end
    ev.stamp = gen_stamp[p];
    gen_live[p] = !(ev.up || ev.cancel) && $urandom_range(0, 99) >= 5;
    return ev;
  endfunction

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_touch(input touch_t ev, input bit known, input gesture_t st,
                            input logic chg);
    in_valid <= 1'b1;
    in_pointer_id <= ev.ptr;
    in_pos_x <= ev.x;
    in_pos_y <= ev.y;
    in_move_dx <= ev.dx;
    in_move_dy <= ev.dy;
    in_elapsed_ms <= ev.dt;
    in_stamp_ms <= ev.stamp;
    in_touch_down <= ev.down;
    in_touch_up <= ev.up;
    in_cancel_flag <= ev.cancel;
    row_known <= known;
    row_st <= st;
    row_chg <= chg;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [15:0] mv, input logic [15:0] spd,
                                input logic [15:0] lp);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_MOVE;
    cfg_wdata <= mv;
    @(posedge clk);
    cfg_index <= CFG_MAX_SPEED;
    cfg_wdata <= spd;
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_move = mv;
    gen_speed = spd;
    gen_lpt = lp;
    @(posedge clk);
  endtask

  initial begin
    touch_row_t rows[$];
    logic [15:0] mv, spd, lp;
    for (int i = 0; i < 16; i++) begin
      gen_live[i] = 1'b0;
      gen_x[i] = '0;
      gen_y[i] = '0;
      gen_stamp[i] = $urandom;
      gen_down_stamp[i] = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // runs under the reset thresholds 60 / 1024 / 500
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_IDLE, 0));
    rows.push_back(mk(0, 32767, -32768, 65535, -65535, 1, 0, 0, 1, 0, 1, ST_IDLE, 0));
    rows.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, ST_NOTAP, 1));
    rows.push_back(mk(2, 0, 0, 0, 0, 0, 1000, 1, 0, 0, 1, ST_AMBIG, 1));
    rows.push_back(mk(2, 10, 10, 10, 10, 100, 1100, 0, 1, 0, 0, ST_IDLE, 0));
    rows.push_back(mk(3, 32767, -32768, 0, 0, 0, 0, 1, 0, 0, 1, ST_AMBIG, 1));
    rows.push_back(mk(3, 32767, -32768, 0, 0, 0, 501, 0, 0, 0, 0, ST_IDLE, 0));
    rows.push_back(mk(3, 32767, -32768, 0, 0, 0, 600, 0, 1, 0, 0, ST_IDLE, 0));
    // hold time across the stamp wrap
    rows.push_back(mk(4, -32768, 32767, 0, 0, 0, 32'hFFFF_FF00, 1, 0, 0, 1, ST_AMBIG, 1));
    rows.push_back(mk(4, -32768, 32767, 0, 0, 0, 32'h0000_0100, 0, 0, 0, 0, ST_IDLE, 0));
    rows.push_back(mk(4, 32767, -32768, 0, 0, 0, 32'h0000_0110, 0, 0, 0, 0, ST_IDLE, 0));
    rows.push_back(mk(5, 0, 0, 0, 0, 0, 10, 1, 0, 0, 1, ST_AMBIG, 1));
    rows.push_back(mk(5, 0, 0, 65535, -65535, 1, 11, 0, 0, 0, 0, ST_IDLE, 0));
    // cancel beats a simultaneous down
    rows.push_back(mk(6, 7, 7, 0, 0, 0, 50, 1, 0, 1, 1, ST_NOTAP, 1));
    rows.push_back(mk(6, 7, 7, 0, 0, 0, 60, 0, 0, 0, 1, ST_IDLE, 0));
    // second down replaces the down data; distance and hold on their limits
    rows.push_back(mk(7, 100, -100, 0, 0, 0, 100, 1, 0, 0, 1, ST_AMBIG, 1));
    rows.push_back(mk(7, 5, 5, 0, 0, 0, 200, 1, 0, 0, 0, ST_IDLE, 0));
    rows.push_back(mk(7, 5, 5, 0, 0, 0, 700, 0, 0, 0, 0, ST_IDLE, 0));
    rows.push_back(mk(7, 65, 5, 0, 0, 0, 701, 0, 0, 0, 0, ST_IDLE, 0));
    rows.push_back(mk(7, 66, 5, 0, 0, 0, 702, 0, 0, 0, 0, ST_IDLE, 0));
    rows.push_back(mk(15, -1, -1, -65535, 65535, 65535, 32'hFFFF_FFFF, 1, 0, 0, 1,
                      ST_AMBIG, 1));
    rows.push_back(mk(15, -1, -1, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 1, 1, ST_NOTAP, 1));
    rows.push_back(mk(8, 300, 300, 500, 500, 1, 5, 0, 1, 0, 1, ST_IDLE, 0));
    // speed exactly on the limit
    rows.push_back(mk(9, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, ST_AMBIG, 1));
    rows.push_back(mk(9, 0, 0, 4, 0, 1, 1, 0, 1, 0, 0, ST_IDLE, 0));

    foreach (rows[i]) begin
      idle_gap();
      send_touch(rows[i].ev, rows[i].known, rows[i].st, rows[i].chg);
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin mv = 16'd0;     spd = 16'd0;     lp = 16'd0;     end
        1: begin mv = 16'hFFFF;  spd = 16'hFFFF;  lp = 16'hFFFF;  end
        2: begin mv = 16'd60;    spd = 16'd1024;  lp = 16'd500;   end
        3: begin mv = 16'd200;   spd = 16'd4096;  lp = 16'd50;    end
        default: begin
          mv = $urandom_range(1, 400);
          spd = $urandom_range(1, 8000);
          lp = $urandom_range(0, 2000);
        end
      endcase
      set_thresholds(mv, spd, lp);
      no_idle <= (ph == 2);
      for (int n = 0; n < 110; n++) begin
        idle_gap();
        send_touch(next_touch(), 1'b0, ST_IDLE, 1'b0);
      end
    end
    in_valid <= 1'b0;
    no_idle <= 1'b0;
    wait_drained();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
